@@ rtl/trc_pkg.sv @@
`timescale 1ns / 1ps
package trc_pkg;

   localparam logic [1:0] CMD_WRITE_OFFSET   = 2'd0;
   localparam logic [1:0] CMD_WRITE_NEIGHBOR = 2'd1;
   localparam logic [1:0] CMD_RUN            = 2'd2;
   localparam logic [1:0] CMD_READ_ROUND     = 2'd3;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_V_ISSUE,
      S_V_CHK,
      S_E_ISSUE,
      S_E_CHK,
      S_U_CHK,
      S_V_END,
      S_ROUND_END
   } state_type;

endpackage

@@ rtl/tree_rake_contraction.sv @@
`timescale 1ns / 1ps
// Loads are taken in the idle state and write the memories directly; a read passes through
// S_READ, which registers the stored round into the response. A run transaction first clears
// the removal rounds, then walks each round twice (leaf marking, then raking) through the
// memories, with issue and check states per vertex and per stored neighbor around the
// registered memory reads. Reset is synchronous and active high; after reset a clearing pass
// over all MAX_VERTICES entries zeroes the removal rounds while no request is accepted.
module tree_rake_contraction
   import trc_pkg::*;
#(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_EDGES    = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [10:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [11:0] req_address,
   input  logic [12:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_vertex,
   output logic [10:0] rsp_round_value
);

   localparam int VI = $clog2(MAX_VERTICES);
   localparam int OA = $clog2(MAX_VERTICES + 1);
   localparam int EW = $clog2(MAX_EDGES);
   localparam int RW = $clog2(MAX_VERTICES + 2);
   localparam int JW = ($clog2(MAX_EDGES + 1) > 13) ? $clog2(MAX_EDGES + 1) : 13;

   logic [12:0] offset_mem [MAX_VERTICES + 1];
   logic [12:0] neighbor_mem [MAX_EDGES];
   logic [RW-1:0] round_mem [MAX_VERTICES];
   logic leaf_mem [MAX_VERTICES];

   state_type state_ff, state_in;
   logic [10:0] vcount_ff;
   logic [VI-1:0] clr_ff, clr_in;
   logic run_ff, run_in;
   logic [OA-1:0] v_ff, v_in;
   logic [JW-1:0] j_ff, j_in, hi_ff, hi_in;
   logic [12:0] u_ff, u_in;
   logic [1:0] cnt_ff, cnt_in;
   logic rake_ff, rake_in;
   logic changed_ff, changed_in;
   logic [RW-1:0] round_ff, round_in;
   logic [RW-1:0] guard_ff, guard_in;
   logic [11:0] addr_ff, addr_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [9:0] rsp_vertex_ff, rsp_vertex_in;
   logic [10:0] rsp_value_ff, rsp_value_in;

   logic [VI-1:0] rr_raddr, rr_waddr, lf_raddr, lf_waddr;
   logic [RW-1:0] rr_wdata, rr_rdata_ff;
   logic rr_we, lf_we, lf_wdata, lf_rdata_ff;
   logic [OA-1:0] off_raddr0, off_raddr1;
   logic [12:0] off_rdata0_ff, off_rdata1_ff, nb_rdata_ff;
   logic [EW-1:0] nb_raddr;

   logic [31:0] n32, a32, v32, hi32, off1_32;
   logic req_take;
   logic [RW-1:0] round_nx;

   assign n32 = (32'(vcount_ff) < 32'(MAX_VERTICES)) ? 32'(vcount_ff) : 32'(MAX_VERTICES);
   assign a32 = 32'(req_address);
   assign v32 = 32'(v_ff);
   assign off1_32 = 32'(off_rdata1_ff);
   assign hi32 = (off1_32 > 32'(MAX_EDGES)) ? 32'(MAX_EDGES) : off1_32;
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_take = req_valid && req_ready;
   assign round_nx = changed_ff ? round_ff + 1'b1 : round_ff;
   assign off_raddr0 = v_ff;
   assign off_raddr1 = v_ff + 1'b1;
   assign nb_raddr = j_ff[EW-1:0];
   assign lf_raddr = u_in[VI-1:0];
   assign lf_waddr = v_ff[VI-1:0];

   always_ff @(posedge clock) begin
      if (req_take && req_command == CMD_WRITE_OFFSET && a32 <= 32'(MAX_VERTICES))
         offset_mem[a32[OA-1:0]] <= req_value;
      if (req_take && req_command == CMD_WRITE_NEIGHBOR && a32 < 32'(MAX_EDGES))
         neighbor_mem[a32[EW-1:0]] <= req_value;
      off_rdata0_ff <= offset_mem[off_raddr0];
      off_rdata1_ff <= offset_mem[off_raddr1];
      nb_rdata_ff <= neighbor_mem[nb_raddr];
      if (rr_we)
         round_mem[rr_waddr] <= rr_wdata;
      rr_rdata_ff <= round_mem[rr_raddr];
      if (lf_we)
         leaf_mem[lf_waddr] <= lf_wdata;
      lf_rdata_ff <= leaf_mem[lf_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         vcount_ff <= 11'd1;
         clr_ff <= '0;
         run_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         changed_ff <= 1'b0;
         round_ff <= RW'(1);
         guard_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable)
            vcount_ff <= csr_write_data;
         clr_ff <= clr_in;
         run_ff <= run_in;
         rsp_valid_ff <= rsp_valid_in;
         changed_ff <= changed_in;
         round_ff <= round_in;
         guard_ff <= guard_in;
      end
      v_ff <= v_in;
      j_ff <= j_in;
      hi_ff <= hi_in;
      u_ff <= u_in;
      cnt_ff <= cnt_in;
      rake_ff <= rake_in;
      addr_ff <= addr_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_value_ff <= rsp_value_in;
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      run_in = run_ff;
      v_in = v_ff;
      j_in = j_ff;
      hi_in = hi_ff;
      u_in = u_ff;
      cnt_in = cnt_ff;
      rake_in = rake_ff;
      changed_in = changed_ff;
      round_in = round_ff;
      guard_in = guard_ff;
      addr_in = addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_value_in = rsp_value_ff;
      rr_raddr = v_ff[VI-1:0];
      rr_we = 1'b0;
      rr_waddr = v_ff[VI-1:0];
      rr_wdata = round_ff;
      lf_we = 1'b0;
      lf_wdata = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            rr_we = 1'b1;
            rr_waddr = clr_ff;
            rr_wdata = '0;
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == 32'(MAX_VERTICES - 1)) begin
               clr_in = '0;
               if (run_ff) begin
                  run_in = 1'b0;
                  round_in = RW'(1);
                  guard_in = '0;
                  changed_in = 1'b0;
                  rake_in = 1'b0;
                  v_in = '0;
                  state_in = S_V_ISSUE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            rr_raddr = a32[VI-1:0];
            addr_in = req_address;
            if (req_take) begin
               case (req_command)
                  CMD_RUN: begin
                     run_in = 1'b1;
                     state_in = S_CLEAR;
                  end
                  CMD_READ_ROUND: state_in = S_READ;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_vertex_in = addr_ff[9:0];
            rsp_value_in = (32'(addr_ff) < 32'(MAX_VERTICES)) ? 11'(rr_rdata_ff) : 11'd0;
            state_in = S_IDLE;
         end
         S_V_ISSUE: begin
            if (v32 >= n32) begin
               v_in = '0;
               if (rake_ff) begin
                  state_in = S_ROUND_END;
               end else begin
                  rake_in = 1'b1;
               end
            end else begin
               state_in = S_V_CHK;
            end
         end
         S_V_CHK: begin
            if (rr_rdata_ff != '0) begin
               v_in = v_ff + 1'b1;
               state_in = S_V_ISSUE;
            end else begin
               j_in = JW'(off_rdata0_ff);
               hi_in = JW'(hi32);
               cnt_in = 2'd0;
               state_in = S_E_ISSUE;
            end
         end
         S_E_ISSUE: begin
            if (32'(j_ff) >= 32'(hi_ff))
               state_in = S_V_END;
            else
               state_in = S_E_CHK;
         end
         S_E_CHK: begin
            u_in = nb_rdata_ff;
            rr_raddr = u_in[VI-1:0];
            if (32'(nb_rdata_ff) < n32) begin
               state_in = S_U_CHK;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = S_E_ISSUE;
            end
         end
         S_U_CHK: begin
            j_in = j_ff + 1'b1;
            state_in = S_E_ISSUE;
            if (rr_rdata_ff == '0) begin
               cnt_in = (cnt_ff == 2'd0) ? 2'd1 : 2'd2;
               if (rake_ff) begin
                  if (lf_rdata_ff) begin
                     rr_we = 1'b1;
                     rr_waddr = u_ff[VI-1:0];
                     changed_in = 1'b1;
                     state_in = S_V_END;
                  end
               end else if (cnt_ff != 2'd0) begin
                  state_in = S_V_END;
               end
            end
         end
         S_V_END: begin
            if (rake_ff) begin
               if (cnt_ff == 2'd0) begin
                  rr_we = 1'b1;
                  changed_in = 1'b1;
               end
            end else begin
               lf_we = 1'b1;
               lf_wdata = (cnt_ff == 2'd1);
            end
            v_in = v_ff + 1'b1;
            state_in = S_V_ISSUE;
         end
         S_ROUND_END: begin
            round_in = round_nx;
            guard_in = guard_ff + 1'b1;
            changed_in = 1'b0;
            rake_in = 1'b0;
            v_in = '0;
            if (changed_ff && 32'(guard_ff) + 32'd1 <= n32) begin
               state_in = S_V_ISSUE;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_vertex_in = 10'd0;
               rsp_value_in = 11'(round_nx - 1'b1);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_vertex = rsp_vertex_ff;
   assign rsp_round_value = rsp_value_ff;

`ifndef SYNTHESIS
   a_one_writer: assert property (@(posedge clock) disable iff (reset) !(rr_we && lf_we))
      else $error("round and leaf memories written in the same cycle");
   a_u_after_e: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_U_CHK |-> $past(state_ff) == S_E_CHK)
      else $error("neighbor check without a neighbor fetch");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_READ || $past(state_ff) == S_ROUND_END)
      else $error("response raised outside a read or round end");
`endif

endmodule
